/* sv/itp_pkg.sv */
`timescale 1ns / 1ps

package itp_pkg;

  // Default sizes
  localparam int STACK_DEPTH_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Operator codes held in the stack and carried through the queue
  typedef enum logic [2:0] {
    CODE_OPERAND = 3'd0,
    CODE_ADD     = 3'd1,
    CODE_SUB     = 3'd2,
    CODE_MUL     = 3'd3,
    CODE_DIV     = 3'd4,
    CODE_POW     = 3'd5,
    CODE_LPAREN  = 3'd6,
    CODE_RPAREN  = 3'd7
  } op_code_t;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNMATCHED = 2'd2,
    STATUS_RSVD      = 2'd3
  } status_t;

  // Back end sequencer states
  typedef enum logic {
    ST_RUN = 1'b0,
    ST_END = 1'b1
  } st_t;

  // Classified item passed from front to back
  typedef struct packed {
    logic       flush;
    op_code_t   code;
    logic [7:0] symbol;
  } item_t;

  // Map an input byte to its operator code
  function automatic op_code_t char_to_code(input logic [7:0] c);
    op_code_t r;
    case (c)
      8'h2B:   r = CODE_ADD;
      8'h2D:   r = CODE_SUB;
      8'h2A:   r = CODE_MUL;
      8'h2F:   r = CODE_DIV;
      8'h5E:   r = CODE_POW;
      8'h28:   r = CODE_LPAREN;
      8'h29:   r = CODE_RPAREN;
      default: r = CODE_OPERAND;
    endcase
    return r;
  endfunction

  // Map a stacked operator code back to its character
  function automatic logic [7:0] code_to_char(input op_code_t c);
    logic [7:0] r;
    unique case (c)
      CODE_ADD:    r = 8'h2B;
      CODE_SUB:    r = 8'h2D;
      CODE_MUL:    r = 8'h2A;
      CODE_DIV:    r = 8'h2F;
      CODE_POW:    r = 8'h5E;
      CODE_LPAREN: r = 8'h28;
      default:     r = 8'h00;
    endcase
    return r;
  endfunction

  // Operator precedence
  function automatic logic [1:0] code_prec(input op_code_t c);
    logic [1:0] r;
    unique case (c)
      CODE_ADD, CODE_SUB: r = 2'd1;
      CODE_MUL, CODE_DIV: r = 2'd2;
      CODE_POW:           r = 2'd3;
      default:            r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

/* sv/itp_if.sv */
`timescale 1ns / 1ps

// Input channel: one character or end-of-expression per transaction
interface itp_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] symbol;

  modport source (output valid, func, symbol, input ready);
  modport sink   (input valid, func, symbol, output ready);
endinterface

// Output channel: one postfix character or error per transaction
interface itp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_symbol;
  logic [1:0] status;
  logic       last;

  modport source (output valid, out_symbol, status, last, input ready);
  modport sink   (input valid, out_symbol, status, last, output ready);
endinterface

/* sv/itp_front.sv */
`timescale 1ns / 1ps

module itp_front (
  input  logic            clk,
  input  logic            rst,
  itp_in_if.sink          in_ch,
  output logic            f_valid,
  output itp_pkg::item_t  f_item,
  input  logic            f_ready
);

  logic take;

  assign in_ch.ready = !f_valid || f_ready;
  assign take        = in_ch.valid && in_ch.ready;

  // Hold one classified transaction until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (take) begin
      f_valid <= 1'b1;
    end else if (f_ready) begin
      f_valid <= 1'b0;
    end
  end

  // Classify the character on capture
  always_ff @(posedge clk) begin
    if (take) begin
      f_item.flush  <= in_ch.func;
      f_item.code   <= itp_pkg::char_to_code(in_ch.symbol);
      f_item.symbol <= in_ch.symbol;
    end
  end

endmodule

/* sv/itp_queue.sv */
`timescale 1ns / 1ps

module itp_queue #(
  parameter int QUEUE_DEPTH = itp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  input  itp_pkg::item_t  wr_item,
  output logic            wr_ready,
  output logic            rd_valid,
  output itp_pkg::item_t  rd_item,
  input  logic            rd_pop
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  itp_pkg::item_t entries [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  fill;
  logic           push;
  logic           pop;

  assign wr_ready = (fill != CW'(QUEUE_DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_item  = entries[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_item;
    end
  end

endmodule

/* sv/itp_back.sv */
`timescale 1ns / 1ps

module itp_back #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  itp_pkg::item_t  q_item,
  output logic            q_pop,
  itp_out_if.source       out_ch
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef struct packed {
    logic              pop;
    logic              push;
    logic              prod;
    logic [7:0]        prod_sym;
    itp_pkg::status_t  prod_status;
    logic              to_end;
    logic              finish;
  } act_t;

  // Operator stack: top in a register, the rest in memory
  itp_pkg::op_code_t stack_mem [STACK_DEPTH];
  itp_pkg::op_code_t top;
  itp_pkg::op_code_t under;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [CW-1:0]     rd_addr;
  logic [CW-1:0]     wr_addr;

  // Pending result, released once the next step shows whether it is last
  logic              pend_valid;
  logic [7:0]        pend_sym;
  itp_pkg::status_t  pend_status;

  itp_pkg::st_t      state;
  itp_pkg::st_t      state_next;
  act_t              act;
  logic              emit_ok;
  logic              can_step;
  logic              pop_ok;
  logic              out_load;

  assign emit_ok  = !out_ch.valid || out_ch.ready;
  assign can_step = q_valid && (!pend_valid || emit_ok);
  assign out_load = pend_valid && (act.prod || act.finish);
  assign q_pop    = act.finish;

  // Stacked operator leaves before the incoming one
  assign pop_ok = (count != '0) && (top != itp_pkg::CODE_LPAREN) &&
                  (itp_pkg::code_prec(top) >= itp_pkg::code_prec(q_item.code));

  // Decide this cycle's step
  always_comb begin
    act = '0;
    act.prod_status = itp_pkg::STATUS_OK;
    unique case (state)
      itp_pkg::ST_RUN: begin
        if (can_step) begin
          if (q_item.flush) begin
            if (count != '0) begin
              act.pop      = 1'b1;
              act.prod     = (top != itp_pkg::CODE_LPAREN);
              act.prod_sym = itp_pkg::code_to_char(top);
            end else begin
              act.to_end = 1'b1;
            end
          end else begin
            case (q_item.code)
              itp_pkg::CODE_OPERAND: begin
                act.prod     = 1'b1;
                act.prod_sym = q_item.symbol;
                act.to_end   = 1'b1;
              end
              itp_pkg::CODE_RPAREN: begin
                if (count != '0) begin
                  act.pop = 1'b1;
                  if (top == itp_pkg::CODE_LPAREN) begin
                    act.to_end = 1'b1;
                  end else begin
                    act.prod     = 1'b1;
                    act.prod_sym = itp_pkg::code_to_char(top);
                  end
                end else begin
                  act.prod        = 1'b1;
                  act.prod_status = itp_pkg::STATUS_UNMATCHED;
                  act.to_end      = 1'b1;
                end
              end
              default: begin
                if (q_item.code != itp_pkg::CODE_LPAREN && pop_ok) begin
                  act.pop      = 1'b1;
                  act.prod     = 1'b1;
                  act.prod_sym = itp_pkg::code_to_char(top);
                end else if (count >= CW'(STACK_DEPTH)) begin
                  act.prod        = 1'b1;
                  act.prod_status = itp_pkg::STATUS_OVERFLOW;
                  act.to_end      = 1'b1;
                end else begin
                  act.push   = 1'b1;
                  act.to_end = 1'b1;
                end
              end
            endcase
          end
        end
      end
      itp_pkg::ST_END: begin
        act.finish = can_step;
      end
      default: begin
        act = '0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      itp_pkg::ST_RUN: if (act.to_end) state_next = itp_pkg::ST_END;
      itp_pkg::ST_END: if (act.finish) state_next = itp_pkg::ST_RUN;
      default:         state_next = itp_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    count_next = count;
    if (act.push) begin
      count_next = count + CW'(1);
    end else if (act.pop) begin
      count_next = count - CW'(1);
    end
  end

  assign rd_addr = count_next - CW'(2);
  assign wr_addr = count - CW'(1);

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= itp_pkg::ST_RUN;
      count        <= '0;
      pend_valid   <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      out_ch.valid <= out_load || (out_ch.valid && !out_ch.ready);
      if (act.prod) begin
        pend_valid <= 1'b1;
      end else if (act.finish) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // Stack memory; under always mirrors the entry below top
  always_ff @(posedge clk) begin
    if (act.push && count != '0) begin
      stack_mem[wr_addr[AW-1:0]] <= top;
    end
    if (act.push) begin
      under <= top;
    end else if (count_next >= CW'(2)) begin
      under <= stack_mem[rd_addr[AW-1:0]];
    end
  end

  // Top of stack
  always_ff @(posedge clk) begin
    if (act.push) begin
      top <= q_item.code;
    end else if (act.pop) begin
      top <= under;
    end
  end

  // Pending result and output register
  always_ff @(posedge clk) begin
    if (act.prod) begin
      pend_sym    <= act.prod_sym;
      pend_status <= act.prod_status;
    end
    if (out_load) begin
      out_ch.out_symbol <= pend_sym;
      out_ch.status     <= pend_status;
      out_ch.last       <= act.finish;
    end
  end

endmodule

/* sv/infix_to_postfix_converter_core.sv */
`timescale 1ns / 1ps

// Shunting-yard infix to postfix converter. Each input transaction carries one
// expression character (func 0) or an end-of-expression marker (func 1) that
// flushes the operator stack. Operands pass through; + - * / ^ are left
// associative with ^ above * / above + -. An input transaction is classified
// in a front register, waits in a short queue, and is carried out by a back
// end that owns the operator stack and does one stack step per cycle unless
// the output stalls. An operand is passed on; an operator pops each stacked
// operator of equal or higher precedence and is then pushed, as is '(';
// ')' pops and passes on operators until it finds and drops its '('; a
// flush pops every stacked entry. Each transaction closes with an end step.
// The result carrying last=1 ends each input transaction; a transaction may
// produce no result at all.
// Stack overflow (status 1) and an unmatched ')' (status 2) give one error
// result with out_symbol 0. No initialization pass is needed after reset.
module infix_to_postfix_converter_core #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF,
  parameter int QUEUE_DEPTH = itp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  itp_in_if.sink     in_ch,
  itp_out_if.source  out_ch
);

  logic            f_valid;
  logic            f_ready;
  itp_pkg::item_t  f_item;
  logic            q_valid;
  logic            q_pop;
  itp_pkg::item_t  q_item;

  itp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .f_valid (f_valid),
    .f_item  (f_item),
    .f_ready (f_ready)
  );

  itp_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_item  (f_item),
    .wr_ready (f_ready),
    .rd_valid (q_valid),
    .rd_item  (q_item),
    .rd_pop   (q_pop)
  );

  itp_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
